>>> rtl/tcd_pkg.sv
// Shared types, constants and the tone lookup for the tone frame command decoder.
package tcd_pkg;

    localparam int unsigned FRAME_NIBBLES = 6;
    localparam int unsigned FRAME_BITS    = 4 * FRAME_NIBBLES;
    localparam int unsigned COUNT_BITS    = 3;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 3'd7;
    localparam logic [COUNT_BITS-1:0] COUNT_FRAME = COUNT_BITS'(FRAME_NIBBLES);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Frame status codes
    localparam logic [2:0] ST_DRIVE     = 3'd0;
    localparam logic [2:0] ST_EXECUTE   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_CSUM_ERR  = 3'd3;
    localparam logic [2:0] ST_LEN_ERR   = 3'd4;

    localparam logic [1:0] CMD_EXECUTE = 2'd0;

    typedef struct packed {
        logic [11:0] tone_hz;
        logic        frame_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0] frame_status;
        logic [1:0] command_code;
        logic [7:0] command_data;
        logic       execute_route;
    } t_out_word;

    // One finished frame handed from front to back
    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  len_ok;
    } t_frame_rec;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    typedef struct packed {
        logic       hit;
        logic [3:0] nibble;
    } t_tone_hit;

    function automatic t_tone_hit tone_lookup(input logic [11:0] hz);
        t_tone_hit r;
        r.hit = 1'b1;
        case (hz)
            12'd2277: r.nibble = 4'h0;
            12'd1906: r.nibble = 4'h1;
            12'd2033: r.nibble = 4'h2;
            12'd2174: r.nibble = 4'h3;
            12'd1979: r.nibble = 4'h4;
            12'd2106: r.nibble = 4'h5;
            12'd2247: r.nibble = 4'h6;
            12'd2061: r.nibble = 4'h7;
            12'd2188: r.nibble = 4'h8;
            12'd2329: r.nibble = 4'h9;
            12'd2330: r.nibble = 4'hA;
            12'd2403: r.nibble = 4'hB;
            12'd2485: r.nibble = 4'hC;
            12'd2574: r.nibble = 4'hD;
            12'd2150: r.nibble = 4'hE;
            12'd2418: r.nibble = 4'hF;
            default: begin
                r.hit    = 1'b0;
                r.nibble = 4'h0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/tcd_front.sv
// Front end: maps tones to nibbles, assembles frames and queues finished ones.
module tcd_front import tcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_word    i_word,
    output logic        o_push,
    output t_frame_rec  o_rec
);

    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [FRAME_BITS-1:0] shifted;
    logic [COUNT_BITS-1:0] count_upd;
    t_tone_hit             tone;

    always_comb begin
        tone      = tone_lookup(i_word.tone_hz);
        shifted   = r_frame;
        count_upd = r_count;
        if (tone.hit) begin
            shifted = {r_frame[FRAME_BITS-5:0], tone.nibble};
            if (r_count != COUNT_MAX) begin
                count_upd = r_count + COUNT_BITS'(1);
            end
        end
        o_rec.frame  = shifted;
        o_rec.len_ok = (count_upd == COUNT_FRAME);
        o_push       = i_accept && i_word.frame_end;
        n_frame      = r_frame;
        n_count      = r_count;
        if (i_accept) begin
            if (i_word.frame_end) begin
                n_frame = '0;
                n_count = '0;
            end else begin
                n_frame = shifted;
                n_count = count_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_count <= '0;
        end else begin
            r_frame <= n_frame;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/tcd_queue.sv
// Short frame queue between the front and back ends.
module tcd_queue import tcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_rec  i_rec,
    input  logic        i_pop,
    output t_frame_rec  o_rec,
    output t_queue_stat o_stat
);

    t_frame_rec           r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count, n_count;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
    endfunction

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
        o_rec        = r_mem[r_rd_ptr];
        n_wr_ptr     = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr     = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count      = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("frame pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("frame popped from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/tcd_back.sv
// Back end: checks, de-duplicates and decodes frames into the output register.
module tcd_back import tcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_stat i_qstat,
    input  t_frame_rec  i_rec,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output t_out_word   o_word
);

    logic [FRAME_BITS-1:0] r_prev_frame, n_prev_frame;
    logic                  r_prev_valid, n_prev_valid;
    logic                  r_exec, n_exec;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;
    logic [8:0]            target;
    logic [8:0]            sum;
    logic [1:0]            code;
    logic [7:0]            data;
    logic [FRAME_BITS-1:0] f;

    always_comb begin
        f      = i_rec.frame;
        target = {f[10:8], f[6:4], f[2:0]};
        sum    = 9'(f[23:20]) + 9'(f[19:12]);
        code   = f[23:22];
        data   = f[19:12];
        if (!f[21]) begin
            data[7:4] = 4'h0;
        end
        if (!f[20]) begin
            data[3:0] = 4'h0;
        end

        o_pop        = !i_qstat.empty && (!r_out_valid || i_ready);
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        n_prev_frame = r_prev_frame;
        n_prev_valid = r_prev_valid;
        n_exec       = r_exec;

        if (o_pop) begin
            n_out_valid        = 1'b1;
            n_out.command_code = '0;
            n_out.command_data = '0;
            if (!i_rec.len_ok) begin
                n_out.frame_status = ST_LEN_ERR;
            end else if (target != sum) begin
                n_out.frame_status = ST_CSUM_ERR;
            end else begin
                n_out.command_code = code;
                n_out.command_data = data;
                if (r_prev_valid && f == r_prev_frame) begin
                    n_out.frame_status = ST_DUPLICATE;
                end else begin
                    n_prev_frame = f;
                    n_prev_valid = 1'b1;
                    if (code == CMD_EXECUTE) begin
                        n_exec             = 1'b1;
                        n_out.frame_status = ST_EXECUTE;
                    end else begin
                        n_out.frame_status = ST_DRIVE;
                    end
                end
            end
            n_out.execute_route = n_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_prev_frame <= n_prev_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_exec       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prev_valid <= n_prev_valid;
            r_exec       <= n_exec;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_exec_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_exec) |-> r_exec)
        else $error("execute flag dropped");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.frame_status == ST_LEN_ERR ||
                         r_out.frame_status == ST_CSUM_ERR))
        |-> (r_out.command_code == '0 && r_out.command_data == '0))
        else $error("rejected frame carries command fields");
    a_exec_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_status == ST_EXECUTE)
        |-> (r_out.execute_route && r_out.command_code == CMD_EXECUTE))
        else $error("execute word without execute route");

endmodule

>>> rtl/tone_frame_command_decoder_core.sv
// Top level of the tone frame command decoder: front end, frame queue, back end.
// Result path: accepting a frame's last tone pushes the frame into the queue; the back end pops it
//   when its output register is free and registers the result on o_word; tones without frame end give no word.
// Throughput: one tone word per cycle; the front end takes a word whenever the
//   two-entry frame queue has room, independent of output stalls until it fills.
// Reset: synchronous active-low i_rst_n clears frame buffer, nibble count, queue,
//   previous-frame valid, execute flag and output valid; payload registers hold.
module tone_frame_command_decoder_core import tcd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    t_queue_stat qstat;
    t_frame_rec  push_rec;
    t_frame_rec  head_rec;
    logic        push;
    logic        pop;
    logic        in_accept;

    // Take a tone word whenever the queue can hold one more finished frame.
    assign o_ready   = !qstat.full;
    assign in_accept = i_valid && o_ready;

    // Front: tone lookup, nibble shift and length count; push the frame on its end.
    tcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_word),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    // Queue: decouple frame assembly from the output stall.
    tcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_stat  (qstat)
    );

    // Back: checksum, duplicate check, execute flag and command decode.
    tcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_rec   (head_rec),
        .o_pop   (pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

endmodule

>>> verif/tone_frame_command_decoder_core_tb.sv
// Self-checking testbench for the tone frame command decoder core.
module tone_frame_command_decoder_core_tb;
    import tcd_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_WORDS     = 200;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word want;
    } t_stim_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_word  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_word;

    // Decoder state as the testbench sees it, all zero out of reset
    logic [23:0] frame_bits    = '0;
    logic [2:0]  nibble_total  = '0;
    logic [23:0] last_frame    = '0;
    logic        last_frame_ok = 1'b0;
    logic        route_flag    = 1'b0;

    t_out_word   expected_words[$];
    t_stim_row   dir_rows[$];
    int          mismatch_count  = 0;
    int          counted_words   = 0;
    int          idle_pct        = 0;
    int          stall_pct       = 0;
    int          hold_off_left   = 0;
    logic [23:0] last_good_frame = '0;

    tone_frame_command_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Tone frequency that stands for each nibble value
    function automatic logic [11:0] nibble_tone(input logic [3:0] nib);
        case (nib)
            4'h0: return 12'd2277;
            4'h1: return 12'd1906;
            4'h2: return 12'd2033;
            4'h3: return 12'd2174;
            4'h4: return 12'd1979;
            4'h5: return 12'd2106;
            4'h6: return 12'd2247;
            4'h7: return 12'd2061;
            4'h8: return 12'd2188;
            4'h9: return 12'd2329;
            4'hA: return 12'd2330;
            4'hB: return 12'd2403;
            4'hC: return 12'd2485;
            4'hD: return 12'd2574;
            4'hE: return 12'd2150;
            default: return 12'd2418;
        endcase
    endfunction

    // Reverse lookup: nibble for a known tone, -1 for anything else
    function automatic int tone_nibble(input logic [11:0] hz);
        for (int n = 0; n < 16; n++) begin
            if (nibble_tone(4'(n)) == hz) return n;
        end
        return -1;
    endfunction

    function automatic logic [11:0] unknown_tone();
        logic [11:0] hz;
        do hz = 12'($urandom_range(0, 4095)); while (tone_nibble(hz) >= 0);
        return hz;
    endfunction

    function automatic t_in_word mk_word(input logic [11:0] hz, input logic last);
        t_in_word w;
        w.tone_hz   = hz;
        w.frame_end = last;
        return w;
    endfunction

    // Random frame whose checksum holds: the low bits carry lead nibble + payload byte
    function automatic logic [23:0] make_good_frame();
        logic [3:0]  lead;
        logic [7:0]  payload;
        logic [8:0]  csum;
        logic [23:0] f;
        lead    = 4'($urandom_range(0, 15));
        payload = 8'($urandom_range(0, 255));
        csum    = 9'(lead) + 9'(payload);
        f       = {lead, payload, 1'($urandom), csum[8:6], 1'($urandom), csum[5:3],
                   1'($urandom), csum[2:0]};
        return f;
    endfunction

    // Advance the decoder state by one accepted word; on frame end, form its result
    function automatic void decode_tone_word(input t_in_word w, output logic produced,
                                             output t_out_word res);
        int          nib;
        logic [23:0] f;
        logic [8:0]  carried;
        logic [8:0]  summed;
        logic [7:0]  data;
        nib      = tone_nibble(w.tone_hz);
        produced = 1'b0;
        res      = '0;
        if (nib >= 0) begin
            frame_bits = {frame_bits[19:0], 4'(nib)};
            if (nibble_total != COUNT_MAX) nibble_total++;
        end
        if (w.frame_end) begin
            f                = frame_bits;
            res.frame_status = ST_LEN_ERR;
            if (nibble_total == 3'(FRAME_NIBBLES)) begin
                carried = {f[10:8], f[6:4], f[2:0]};
                summed  = 9'(f[23:20]) + 9'(f[19:12]);
                if (carried != summed) begin
                    res.frame_status = ST_CSUM_ERR;
                end else begin
                    // Each half of the data survives only with its enable bit set
                    data = f[19:12];
                    if (!f[21]) data[7:4] = 4'h0;
                    if (!f[20]) data[3:0] = 4'h0;
                    res.command_code = f[23:22];
                    res.command_data = data;
                    if (last_frame_ok && f == last_frame) begin
                        res.frame_status = ST_DUPLICATE;
                    end else begin
                        last_frame    = f;
                        last_frame_ok = 1'b1;
                        if (f[23:22] == CMD_EXECUTE) begin
                            route_flag       = 1'b1;
                            res.frame_status = ST_EXECUTE;
                        end else begin
                            res.frame_status = ST_DRIVE;
                        end
                    end
                end
            end
            res.execute_route = route_flag;
            frame_bits        = '0;
            nibble_total      = '0;
            produced          = 1'b1;
        end
    endfunction

    function automatic void add_row(input logic [11:0] hz, input logic last,
                                    input logic typed, input logic [2:0] status,
                                    input logic [1:0] code, input logic [7:0] data,
                                    input logic route);
        t_stim_row r;
        r.word   = mk_word(hz, last);
        r.typed  = typed;
        r.want   = {status, code, data, route};
        dir_rows = {dir_rows, r};
    endfunction

    // Drive one word from a falling edge; hold it until accepted, then predict it
    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        logic      produced;
        t_out_word predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (!o_ready);
        decode_tone_word(w, produced, predicted);
        if (produced) expected_words = {expected_words, (typed ? want : predicted)};
        if (w.frame_end || tone_nibble(w.tone_hz) >= 0) counted_words++;
        @(negedge i_clk);
    endtask

    // Send count nibbles, most significant first, with unknown tones sprinkled in
    task automatic send_nibbles(input logic [35:0] nibs, input int count,
                                input int noise_pct, input logic end_on_unknown);
        for (int i = count - 1; i >= 0; i--) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(mk_word(unknown_tone(), 1'b0), 1'b0, '0);
            send_word(mk_word(nibble_tone(nibs[4*i +: 4]), (i == 0) && !end_on_unknown),
                      1'b0, '0);
        end
        if (end_on_unknown || count == 0)
            send_word(mk_word(unknown_tone(), 1'b1), 1'b0, '0);
    endtask

    // Mostly well-formed frames with random content; the rest repeats, bad sums,
    // wrong lengths and raw noise
    task automatic run_random(input int quota);
        int          stop_at;
        int          pick;
        int          count;
        logic [35:0] nibs;
        stop_at = counted_words + quota;
        while (counted_words < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                last_good_frame = make_good_frame();
                send_nibbles({12'h0, last_good_frame}, 6, 10, $urandom_range(0, 6) == 0);
            end else if (pick < 68) begin
                // resend the last good frame: duplicate unless something was accepted since
                send_nibbles({12'h0, last_good_frame}, 6, 10, 1'b0);
            end else if (pick < 78) begin
                send_nibbles({12'h0, 24'($urandom)}, 6, 10, 1'b0);
            end else if (pick < 90) begin
                // anything but six nibbles, up to nine so the count saturates
                count = $urandom_range(0, 9);
                if (count == 6) count = 7;
                nibs  = {4'($urandom), 32'($urandom)};
                send_nibbles(nibs, count, 10, $urandom_range(0, 3) == 0);
            end else begin
                repeat ($urandom_range(1, 3))
                    send_word(mk_word(12'($urandom_range(0, 4095)), $urandom_range(0, 7) == 0),
                              1'b0, '0);
            end
        end
    endtask

    // Hold the sender until every expected word has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected word: status %0d code %0d data %02h route %0d",
                         got.frame_status, got.command_code, got.command_data,
                         got.execute_route);
        end else begin
            want = expected_words.pop_front();
            if (got.frame_status  !== want.frame_status  ||
                got.command_code  !== want.command_code  ||
                got.command_data  !== want.command_data  ||
                got.execute_route !== want.execute_route) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch: expected %0d/%0d/%02h/%0d, got %0d/%0d/%02h/%0d",
                             want.frame_status, want.command_code, want.command_data,
                             want.execute_route, got.frame_status, got.command_code,
                             got.command_data, got.execute_route);
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off counted down here
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_ready <= 1'b0;
                hold_off_left--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Sample result words at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_word(o_word);
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : main_seq
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty frames at the bottom and top of the tone range: length errors
        add_row(12'd0,    1'b1, 1'b1, ST_LEN_ERR,   2'd0, 8'h00, 1'b0);
        add_row(12'd4095, 1'b1, 1'b1, ST_LEN_ERR,   2'd0, 8'h00, 1'b0);
        // All-zero frame: checksum holds, code 0 executes and sets the route flag
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b1, 1'b1, ST_EXECUTE,   2'd0, 8'h00, 1'b1);
        // Same frame again: duplicate ack
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b1, 1'b1, ST_DUPLICATE, 2'd0, 8'h00, 1'b1);
        // Lead nibble 1 with all-zero check bits: checksum error
        add_row(12'd1906, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2277, 1'b1, 1'b1, ST_CSUM_ERR,  2'd0, 8'h00, 1'b1);
        // Largest checksum (15 + 255): forward with both data halves enabled
        add_row(12'd2418, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2418, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2418, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd1979, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd1906, 1'b0, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);
        add_row(12'd2247, 1'b1, 1'b0, ST_DRIVE,     2'd0, 8'h00, 1'b0);

        foreach (dir_rows[k]) send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
        wait_drained();

        // No idling on either side
        idle_pct  = 0;
        stall_pct = 0;
        run_random(PHASE_WORDS);
        wait_drained();

        // Long receiver hold-off while the sender keeps streaming: the frame
        // queue fills and o_ready must drop
        @(posedge i_clk);
        hold_off_left = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        run_random(80);
        wait_drained();

        // Sender mostly idle
        idle_pct = 77;
        run_random(PHASE_WORDS);
        wait_drained();

        // Receiver mostly stalled
        idle_pct  = 0;
        stall_pct = 77;
        run_random(PHASE_WORDS);
        wait_drained();

        // Both sides idling now and then
        idle_pct  = 30;
        stall_pct = 30;
        run_random(PHASE_WORDS);
        wait_drained();

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
